[rtl/ppcm_pkg.sv]
package ppcm_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned ADDR_W    = 30;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PING_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PONG_BASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} ppcm_state_t;

	typedef struct packed {
		logic cap_load;
		logic rd_issue;
		logic mir_load;
	} ppcm_cmd_t;

	typedef struct packed {
		logic full;
		logic rd_last;
		logic out_free;
	} ppcm_sts_t;

endpackage

[rtl/ppcm_sample_if.sv]
interface ppcm_sample_if import ppcm_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

[rtl/ppcm_write_if.sv]
interface ppcm_write_if import ppcm_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic        [ADDR_W-1:0] write_addr;
	logic signed [DATA_W-1:0] write_data;
	logic                     is_mirror;
	logic                     active_buffer;
	logic                     last;

	modport source (output valid, output write_addr, output write_data, output is_mirror,
		output active_buffer, output last, input ready);
	modport sink   (input valid, input write_addr, input write_data, input is_mirror,
		input active_buffer, input last, output ready);
endinterface

[rtl/ppcm_ctrl.sv]
module ppcm_ctrl import ppcm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ppcm_sts_t sts,
	output ppcm_cmd_t cmd
);

	ppcm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready     = sts.out_free;
				cmd.cap_load = in_valid && sts.out_free;
				if (cmd.cap_load && sts.full) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_WRITE;
			end
			ST_WRITE: begin
				// hold until the output register can take the mirror word
				if (sts.out_free) begin
					cmd.mir_load = 1'b1;
					state_d      = sts.rd_last ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/ppcm_dp.sv]
module ppcm_dp import ppcm_pkg::*; #(
	parameter int unsigned BLOCK_SAMPLES = 50
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_idx,
	input  logic [DATA_W-1:0]        cfg_wdata,
	input  logic signed [DATA_W-1:0] sample,
	input  ppcm_cmd_t                cmd,
	output ppcm_sts_t                sts,
	ppcm_write_if.source             write_ch
);

	localparam int unsigned IDX_W  = $clog2(BLOCK_SAMPLES + 1);
	localparam int unsigned MEM_AW = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;

	logic [DATA_W-1:0] ping_base_q, pong_base_q, dest_base_q;
	logic              fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_next;
	logic [MEM_AW-1:0] rd_cnt_q;
	logic [DATA_W-1:0] mem_q [BLOCK_SAMPLES];
	logic [DATA_W-1:0] rd_data_q;
	logic [DATA_W-1:0] cap_base;
	logic [ADDR_W-1:0] cap_addr;
	logic [ADDR_W-1:0] mir_addr;
	logic              out_valid_q;

	assign idx_next = idx_q + IDX_W'(1);
	assign cap_base = fill_q ? pong_base_q : ping_base_q;
	assign cap_addr = cap_base[DATA_W-1:2] + ADDR_W'(idx_q);
	assign mir_addr = dest_base_q[DATA_W-1:2] + ADDR_W'(rd_cnt_q);

	assign sts.full     = (idx_next == IDX_W'(BLOCK_SAMPLES));
	assign sts.rd_last  = (rd_cnt_q == MEM_AW'(BLOCK_SAMPLES - 1));
	assign sts.out_free = !out_valid_q || write_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_base_q <= '0;
			pong_base_q <= '0;
			dest_base_q <= '0;
			fill_q      <= 1'b0;
			idx_q       <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PING_BASE: ping_base_q <= cfg_wdata;
					CFG_PONG_BASE: pong_base_q <= cfg_wdata;
					CFG_DEST_BASE: dest_base_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.cap_load) begin
				rd_cnt_q <= '0;
				if (sts.full) begin
					idx_q  <= '0;
					fill_q <= !fill_q;
				end else begin
					idx_q <= idx_next;
				end
			end else if (cmd.mir_load) begin
				rd_cnt_q <= rd_cnt_q + MEM_AW'(1);
			end
			if (cmd.cap_load || cmd.mir_load) begin
				out_valid_q <= 1'b1;
			end else if (write_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_load) begin
			mem_q[idx_q[MEM_AW-1:0]] <= sample;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem_q[rd_cnt_q];
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.cap_load) begin
			write_ch.write_addr    <= cap_addr;
			write_ch.write_data    <= sample;
			write_ch.is_mirror     <= 1'b0;
			write_ch.active_buffer <= fill_q ^ sts.full;
			write_ch.last          <= !sts.full;
		end else if (cmd.mir_load) begin
			write_ch.write_addr    <= mir_addr;
			write_ch.write_data    <= rd_data_q;
			write_ch.is_mirror     <= 1'b1;
			write_ch.active_buffer <= fill_q;
			write_ch.last          <= sts.rd_last;
		end
	end

	assign write_ch.valid = out_valid_q;

endmodule

[rtl/ping_pong_capture_mirror_core.sv]
// A capture write is registered and appears on write_ch in the cycle after its sample is accepted.
// Throughput: one sample per cycle while a block fills and write_ch takes every write; the sample
// that completes a block adds a mirror burst of BLOCK_SAMPLES writes, each a registered block-copy
// memory read then an output register load, and no new sample is taken until that burst ends.
// Reset (arst_n low): base registers, buffer select, write index and output valid clear;
// the block-copy memory is not cleared, every entry is written before it is mirrored.
module ping_pong_capture_mirror_core import ppcm_pkg::*; #(
	parameter int unsigned BLOCK_SAMPLES = 50
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DATA_W-1:0]    cfg_wdata,
	ppcm_sample_if.sink          sample_ch,
	ppcm_write_if.source         write_ch
);

	ppcm_cmd_t cmd;
	ppcm_sts_t sts;

	// Controller: accepts a sample when the output register is free, then
	// sequences the mirror burst (read the copy, load the output) word by word.
	ppcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: base registers, buffer select, write index, local block copy
	// and the output register that parts the two handshake sides.
	ppcm_dp #(
		.BLOCK_SAMPLES (BLOCK_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.sample    (sample_ch.sample),
		.cmd       (cmd),
		.sts       (sts),
		.write_ch  (write_ch)
	);

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb import ppcm_pkg::*;;

	localparam int unsigned BLOCK_SAMPLES = 50;
	localparam int unsigned MAX_REPORTS   = 10;
	// Drain length: the longest mirror burst, plus slack for the output register.
	localparam int unsigned DRAIN_CYCLES  = 2 * BLOCK_SAMPLES + 8;
	// Index 3 decodes to no register; writes to it must leave every base untouched.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// One memory write as the block should emit it.
	typedef struct {
		logic [ADDR_W-1:0]        addr;
		logic signed [DATA_W-1:0] data;
		logic                     mirror;
		logic                     buf_sel;
		logic                     last;
	} mem_write_t;

	// Receiver backpressure shapes, drawn at random by the receiver.
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_THIRD,
		RX_STALL
	} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DATA_W-1:0]    cfg_wdata;

	ppcm_sample_if smp ();
	ppcm_write_if  wr ();

	ping_pong_capture_mirror_core #(
		.BLOCK_SAMPLES(BLOCK_SAMPLES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.sample_ch(smp),
		.write_ch (wr)
	);

	// Shadow of the block: base registers, buffer select, fill index and the local copy.
	logic [DATA_W-1:0]        ping_base_m;
	logic [DATA_W-1:0]        pong_base_m;
	logic [DATA_W-1:0]        dest_base_m;
	logic                     fill_pong;
	logic [5:0]               fill_index;
	logic signed [DATA_W-1:0] block_words [BLOCK_SAMPLES];

	// Writes predicted but not yet seen on write_ch, oldest first.
	mem_write_t pending_writes [$];

	int n_samples;
	int n_capture;
	int n_mirror;
	int n_flips;
	int n_mismatch;
	int n_unexpected;
	int burst_left;

	rx_mode_t rx_mode;
	int       rx_cycle;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Work out every write one accepted sample causes and queue them in order:
	// the capture write first, then the mirror burst when the block fills.
	task automatic predict_writes(input logic signed [DATA_W-1:0] s);
		logic [DATA_W-1:0] base;
		logic [ADDR_W-1:0] cap_addr;
		logic [ADDR_W-1:0] dest_word;
		logic [5:0]        next_index;
		int                i;
		base       = fill_pong ? pong_base_m : ping_base_m;
		// Word address wraps at 30 bits.
		cap_addr   = base[DATA_W-1:2] + ADDR_W'(fill_index);
		block_words[fill_index] = s;
		next_index = fill_index + 6'd1;
		if (next_index != 6'(BLOCK_SAMPLES)) begin
			fill_index = next_index;
			pending_writes.push_back('{cap_addr, s, 1'b0, fill_pong, 1'b1});
		end else begin
			// Block complete: flip first, every write of this sample carries the new buffer.
			fill_index = '0;
			fill_pong  = ~fill_pong;
			n_flips++;
			pending_writes.push_back('{cap_addr, s, 1'b0, fill_pong, 1'b0});
			dest_word = dest_base_m[DATA_W-1:2];
			for (i = 0; i < BLOCK_SAMPLES; i++) begin
				pending_writes.push_back('{dest_word + ADDR_W'(i), block_words[i], 1'b1,
					fill_pong, i == BLOCK_SAMPLES - 1});
			end
		end
	endtask

	// Write one register; only called while nothing is in flight.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			CFG_PING_BASE: ping_base_m = value;
			CFG_PONG_BASE: pong_base_m = value;
			CFG_DEST_BASE: dest_base_m = value;
			default: ;
		endcase
	endtask

	// Send one sample item. The sender runs in bursts; between bursts hold valid low
	// for a random gap and put noise on the payload.
	task automatic send_sample(input logic signed [DATA_W-1:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 7);
			@(negedge clk);
			smp.valid  <= 1'b0;
			smp.sample <= $urandom;
			repeat (gap) begin
				@(negedge clk);
				smp.sample <= $urandom;
			end
			// Now and then a long burst, so stretches with no sender idling occur.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		@(negedge clk);
		smp.valid  <= 1'b1;
		smp.sample <= s;
		do @(posedge clk); while (!smp.ready);
		predict_writes(s);
		n_samples++;
		burst_left--;
	endtask

	// Drop valid and wait until every predicted write has been seen.
	task automatic wait_idle();
		@(negedge clk);
		smp.valid <= 1'b0;
		burst_left = 0;
		while (pending_writes.size() != 0) @(posedge clk);
	endtask

	// Mostly random words, with the extremes mixed in.
	function automatic logic signed [DATA_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh0000_0000;
			3: return 32'shFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Phase 1 pins every base at the top of the space, phase 2 at zero; the rest mix.
	function automatic logic [DATA_W-1:0] pick_base(input int phase);
		case (phase)
			1: return 32'hFFFF_FFFF;
			2: return 32'h0000_0000;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'hFFFF_FFFC;
					1: return 32'h0000_0003;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// Bases are zero after reset: capture lands at word 0, 1, 2 of ping.
	task automatic test_reset_state();
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh0000_0000);
		wait_idle();
	endtask

	// A write to the unused index must change nothing.
	task automatic test_ignored_index();
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		send_sample(32'shFFFF_FFFF);
		send_sample(32'sh5555_5555);
		wait_idle();
	endtask

	// Ping base at the top of the space: base/4 + index wraps past 2^30.
	task automatic test_address_wrap();
		int k;
		write_reg(CFG_PING_BASE, 32'hFFFF_FFFF);
		write_reg(CFG_PONG_BASE, 32'hFFFF_FFFC);
		write_reg(CFG_DEST_BASE, 32'hFFFF_FFF0);
		send_sample(32'shAAAA_AAAA);
		for (k = 0; k < 13; k++) send_sample(pick_sample());
		wait_idle();
	endtask

	// Byte offsets in the two low base bits are dropped from the word address.
	task automatic test_low_bits();
		write_reg(CFG_PING_BASE, 32'h0000_0003);
		write_reg(CFG_DEST_BASE, 32'h8000_0007);
		send_sample(32'sh0000_0001);
		send_sample(32'sh8000_0001);
		send_sample(pick_sample());
		send_sample(pick_sample());
		wait_idle();
	endtask

	// Random samples in phases; rewrite every base between phases. Block boundaries
	// fall inside phases, so mirror bursts run under several base settings.
	task automatic test_random_stream();
		int phase;
		int k;
		for (phase = 0; phase < 5; phase++) begin
			write_reg(CFG_PING_BASE, pick_base(phase));
			write_reg(CFG_PONG_BASE, pick_base(phase));
			write_reg(CFG_DEST_BASE, pick_base(phase));
			if ($urandom_range(0, 1) == 1) write_reg(CFG_UNUSED, $urandom);
			for (k = 0; k < 17; k++) send_sample(pick_sample());
			wait_idle();
		end
	endtask

	// Receiver: drive ready at the falling edge on a pattern that is redrawn at random, paced by rx_cycle.
	always @(negedge clk) begin
		if (rx_cycle % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_OPEN:  wr.ready <= 1'b1;
			RX_COIN:  wr.ready <= 1'($urandom_range(0, 1));
			RX_THIRD: wr.ready <= (rx_cycle % 3 == 0);
			default:  wr.ready <= (rx_cycle % 10 >= 7);
		endcase
		rx_cycle++;
	end

	// Check every accepted write against the oldest prediction, field by field.
	always @(posedge clk) begin : check_writes
		mem_write_t want;
		if (arst_n && wr.valid && wr.ready) begin
			if (pending_writes.size() == 0) begin
				n_unexpected++;
				if (n_unexpected + n_mismatch <= MAX_REPORTS)
					$display("unexpected write: addr %h data %h mirror %b buf %b last %b",
						wr.write_addr, wr.write_data, wr.is_mirror, wr.active_buffer, wr.last);
			end else begin
				want = pending_writes.pop_front();
				if (wr.write_addr !== want.addr || wr.write_data !== want.data ||
					wr.is_mirror !== want.mirror || wr.active_buffer !== want.buf_sel ||
					wr.last !== want.last) begin
					n_mismatch++;
					if (n_unexpected + n_mismatch <= MAX_REPORTS) begin
						$display("mismatch: expected addr %h data %h mirror %b buf %b last %b",
							want.addr, want.data, want.mirror, want.buf_sel, want.last);
						$display("          actual   addr %h data %h mirror %b buf %b last %b",
							wr.write_addr, wr.write_data, wr.is_mirror, wr.active_buffer,
							wr.last);
					end
				end
				if (wr.is_mirror) n_mirror++;
				else n_capture++;
			end
		end
	end

	initial begin
		// Drive every input known from time zero and hold reset.
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = CFG_PING_BASE;
		cfg_wdata   = '0;
		smp.valid   = 1'b0;
		smp.sample  = '0;
		wr.ready    = 1'b0;
		ping_base_m = '0;
		pong_base_m = '0;
		dest_base_m = '0;
		fill_pong   = 1'b0;
		fill_index  = '0;
		rx_mode     = RX_OPEN;
		rx_cycle    = 0;
		burst_left  = 0;
		n_samples   = 0;
		n_capture   = 0;
		n_mirror    = 0;
		n_flips     = 0;
		n_mismatch  = 0;
		n_unexpected = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_ignored_index();
		test_address_wrap();
		test_low_bits();
		test_random_stream();

		// Drain, then watch a full burst length for stray writes.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d samples, %0d capture and %0d mirror writes checked, %0d flips",
			n_samples, n_capture, n_mirror, n_flips);
		$display("summary: %0d mismatches, %0d unexpected writes, %0d writes never seen",
			n_mismatch, n_unexpected, pending_writes.size());
		if (n_mismatch == 0 && n_unexpected == 0 && pending_writes.size() == 0) begin
			$display("ping_pong_capture_mirror_core verification clean");
		end else begin
			$display("ping_pong_capture_mirror_core verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("ping_pong_capture_mirror_core verification failed");
		$finish;
	end

endmodule

[ping_pong_capture_mirror_core.f]
rtl/ppcm_pkg.sv
rtl/ppcm_sample_if.sv
rtl/ppcm_write_if.sv
rtl/ppcm_ctrl.sv
rtl/ppcm_dp.sv
rtl/ping_pong_capture_mirror_core.sv
dv/tb.sv
